// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker module of the deframer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication; expects clk and arst_n in the enclosing scope.
`define ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// Next-cycle implication; expects clk and arst_n in the enclosing scope.
`define ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

// File: hw/rtl/dsrd_pkg.sv
// Shared constants and types of the DLE/STX reply deframer.
`default_nettype none

package dsrd_pkg;

	localparam int MAX_PAYLOAD = 512;
	localparam int BANK_SIZE   = MAX_PAYLOAD + 8;
	localparam int STORE_DEPTH = 2 * BANK_SIZE;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(BANK_SIZE + 1);
	localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
	localparam int IDX_W       = $clog2(MAX_PAYLOAD);
	localparam int HDR_CK_LEN  = 6;
	localparam int PAYLOAD_OFS = 5;

	localparam logic [7:0] DLE_BYTE = 8'h10;
	localparam logic [7:0] STX_BYTE = 8'h02;

	typedef enum logic [1:0] {
		OP_RX_BYTE = 2'd0,
		OP_ARM     = 2'd1,
		OP_CANCEL  = 2'd2,
		OP_READ    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		EV_NONE        = 3'd0,
		EV_CAPTURED    = 3'd1,
		EV_UNSOLICITED = 3'd2,
		EV_BAD_SUM     = 3'd3,
		EV_RUNT        = 3'd4,
		EV_LEN_RESYNC  = 3'd5
	} event_t;

endpackage

`default_nettype wire

// File: hw/rtl/dsrd_in_if.sv
// Request channel of the deframer: operation and its operands.
`default_nettype none

interface dsrd_in_if import dsrd_pkg::*; ();

	logic             valid;
	logic             ready;
	op_t              operation;
	logic [7:0]       data_byte;
	logic [7:0]       expect_seq;
	logic [IDX_W-1:0] read_index;

	modport source (output valid, output operation, output data_byte, output expect_seq,
		output read_index, input ready);
	modport sink (input valid, input operation, input data_byte, input expect_seq,
		input read_index, output ready);

endinterface

`default_nettype wire

// File: hw/rtl/dsrd_out_if.sv
// Result channel of the deframer: frame event, held reply status and read data.
`default_nettype none

interface dsrd_out_if import dsrd_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [2:0]       frame_event;
	logic             reply_ready;
	logic             awaiting;
	logic [7:0]       reply_opcode;
	logic [7:0]       reply_seq;
	logic [LEN_W-1:0] reply_len;
	logic [7:0]       read_data;

	modport source (output valid, output frame_event, output reply_ready, output awaiting,
		output reply_opcode, output reply_seq, output reply_len, output read_data,
		input ready);
	modport sink (input valid, input frame_event, input reply_ready, input awaiting,
		input reply_opcode, input reply_seq, input reply_len, input read_data,
		output ready);

endinterface

`default_nettype wire

// File: hw/rtl/dle_stx_reply_deframer.sv
// A result is valid in the cycle after its request transaction is accepted.
// Throughput: one request per cycle while results are taken; the frame store has one
// write port and one registered read port, and no request needs both in the same cycle.
// Reset (arst_n low, asynchronous): decoder hunts for DLE, bank 0 active, no wait
// armed, no reply held. The frame store is not cleared; reads stay inside held_len.
`default_nettype none

module dle_stx_reply_deframer import dsrd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	dsrd_in_if.sink    req,
	dsrd_out_if.source rsp
);

	typedef enum logic [3:0] {
		PH_IDLE     = 4'b0001,
		PH_GOT_DLE  = 4'b0010,
		PH_BODY     = 4'b0100,
		PH_BODY_DLE = 4'b1000
	} phase_t;

	// body offsets of the header bytes that are kept in registers
	localparam logic [CNT_W-1:0] OFS_OPCODE = CNT_W'(0);
	localparam logic [CNT_W-1:0] OFS_SEQ    = CNT_W'(1);
	localparam logic [CNT_W-1:0] OFS_LEN_HI = CNT_W'(3);
	localparam logic [CNT_W-1:0] OFS_LEN_LO = CNT_W'(4);

	// decoder state
	phase_t           phase_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       sum_q;
	logic             bank_q;
	// header bytes of the body being gathered (copies of store entries)
	logic [7:0]       hdr_op_q;
	logic [7:0]       hdr_seq_q;
	logic [7:0]       hdr_hi_q;
	logic [7:0]       hdr_lo_q;
	// wait and held reply
	logic             armed_q;
	logic [7:0]       wanted_q;
	logic             held_ready_q;
	logic [7:0]       held_op_q;
	logic [7:0]       held_seq_q;
	logic [LEN_W-1:0] held_len_q;
	// result register
	logic             out_valid_q;
	event_t           ev_q;
	logic             rd_hit_q;
	logic [7:0]       rd_data_q;

	logic [7:0]       frame_mem [STORE_DEPTH];

	// next-state values
	logic             accept;
	phase_t           phase_n;
	logic [CNT_W-1:0] cnt_a;
	logic [7:0]       sum_a;
	logic             app;
	logic             do_fin;
	logic             clear;
	event_t           ev_n;
	logic             armed_n;
	logic             held_ready_n;
	logic             cap;
	logic [15:0]      decl_len;
	logic [CNT_W-1:0] avail;
	logic [LEN_W-1:0] fin_len;
	event_t           fin_ev;
	logic             fin_cap;
	logic             rd_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;

	// Take a request whenever the result register is empty or being drained.
	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign decl_len = {hdr_hi_q, hdr_lo_q};

	// Byte decoder: unstuff, append, then check the declared length once the
	// header is complete. At most one frame completes per byte.
	always_comb begin
		phase_n = phase_q;
		app     = 1'b0;
		do_fin  = 1'b0;
		clear   = 1'b0;
		if (accept && req.operation == OP_RX_BYTE) begin
			case (phase_q)
				PH_IDLE: begin
					if (req.data_byte == DLE_BYTE) phase_n = PH_GOT_DLE;
				end
				PH_GOT_DLE: begin
					phase_n = (req.data_byte == STX_BYTE) ? PH_BODY : PH_IDLE;
					clear   = 1'b1;
				end
				PH_BODY: begin
					if (req.data_byte == DLE_BYTE) begin
						phase_n = PH_BODY_DLE;
					end else if (cnt_q < CNT_W'(BANK_SIZE)) begin
						app = 1'b1;
					end else begin
						// bank overflow: drop the body and hunt again
						phase_n = PH_IDLE;
					end
				end
				PH_BODY_DLE: begin
					if (req.data_byte == DLE_BYTE) begin
						// stuffed DLE; drop it silently when the bank is full
						app     = cnt_q < CNT_W'(BANK_SIZE);
						phase_n = PH_BODY;
					end else if (req.data_byte == STX_BYTE) begin
						// new frame start closes the current body
						do_fin  = 1'b1;
						phase_n = PH_BODY;
					end else begin
						// bad escape
						phase_n = PH_IDLE;
					end
				end
				default: phase_n = PH_IDLE;
			endcase
		end
	end

	// Count and checksum after the append of this byte.
	assign cnt_a = app ? cnt_q + CNT_W'(1) : cnt_q;
	assign sum_a = app ? sum_q + req.data_byte : sum_q;

	// Frame verdict on the body as it stands after this byte.
	assign avail   = cnt_a - CNT_W'(HDR_CK_LEN);
	assign fin_len = (decl_len > 16'(avail)) ? LEN_W'(avail) : LEN_W'(decl_len);

	always_comb begin
		fin_ev  = EV_NONE;
		fin_cap = 1'b0;
		if (cnt_a == '0) begin
			fin_ev = EV_NONE;
		end else if (cnt_a < CNT_W'(HDR_CK_LEN)) begin
			fin_ev = EV_RUNT;
		end else if (sum_a != 8'h00) begin
			fin_ev = EV_BAD_SUM;
		end else if (armed_q && hdr_seq_q == wanted_q) begin
			fin_ev  = EV_CAPTURED;
			fin_cap = 1'b1;
		end else begin
			fin_ev = EV_UNSOLICITED;
		end
	end

	// Length check, completion and event selection.
	logic [CNT_W-1:0] cnt_n;
	logic [7:0]       sum_n;
	phase_t           phase_f;

	always_comb begin
		phase_f = phase_n;
		ev_n    = EV_NONE;
		cap     = 1'b0;
		cnt_n   = cnt_a;
		sum_n   = sum_a;
		if (phase_n == PH_BODY && !do_fin && !clear && cnt_a >= CNT_W'(HDR_CK_LEN)) begin
			if (decl_len > 16'(MAX_PAYLOAD)) begin
				// implausible length: resync the decoder
				phase_f = PH_IDLE;
				ev_n    = EV_LEN_RESYNC;
				cnt_n   = '0;
				sum_n   = 8'h00;
			end else if (17'(cnt_a) >= 17'(decl_len) + 17'(HDR_CK_LEN)) begin
				// declared length reached: complete, stay in the body phase
				ev_n  = fin_ev;
				cap   = fin_cap;
				cnt_n = '0;
				sum_n = 8'h00;
			end
		end
		if (do_fin) begin
			ev_n  = fin_ev;
			cap   = fin_cap;
			cnt_n = '0;
			sum_n = 8'h00;
		end
		if (clear) begin
			cnt_n = '0;
			sum_n = 8'h00;
		end
	end

	// Wait bookkeeping.
	always_comb begin
		armed_n      = armed_q;
		held_ready_n = held_ready_q;
		if (accept && req.operation == OP_ARM) begin
			armed_n      = 1'b1;
			held_ready_n = 1'b0;
		end else if (accept && req.operation == OP_CANCEL) begin
			armed_n = 1'b0;
		end else if (cap) begin
			armed_n      = 1'b0;
			held_ready_n = 1'b1;
		end
	end

	// Store addressing: append into the active bank, read the held (other) bank.
	assign wr_addr = (bank_q ? ADDR_W'(BANK_SIZE) : ADDR_W'(0)) + ADDR_W'(cnt_q);
	assign rd_addr = (bank_q ? ADDR_W'(0) : ADDR_W'(BANK_SIZE)) + ADDR_W'(PAYLOAD_OFS)
		+ ADDR_W'(req.read_index);
	assign rd_en   = accept && req.operation == OP_READ
		&& LEN_W'(req.read_index) < held_len_q;

	always_ff @(posedge clk) begin
		if (app) frame_mem[wr_addr] <= req.data_byte;
		if (rd_en) rd_data_q <= frame_mem[rd_addr];
	end

	// Header copies: capture on append at the fixed body offsets.
	always_ff @(posedge clk) begin
		if (app) begin
			if (cnt_q == OFS_OPCODE) hdr_op_q <= req.data_byte;
			if (cnt_q == OFS_SEQ) hdr_seq_q <= req.data_byte;
			if (cnt_q == OFS_LEN_HI) hdr_hi_q <= req.data_byte;
			if (cnt_q == OFS_LEN_LO) hdr_lo_q <= req.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			cnt_q        <= '0;
			sum_q        <= 8'h00;
			bank_q       <= 1'b0;
			armed_q      <= 1'b0;
			wanted_q     <= 8'h00;
			held_ready_q <= 1'b0;
			held_op_q    <= 8'h00;
			held_seq_q   <= 8'h00;
			held_len_q   <= '0;
			out_valid_q  <= 1'b0;
			ev_q         <= EV_NONE;
			rd_hit_q     <= 1'b0;
		end else begin
			if (accept) begin
				phase_q      <= phase_f;
				cnt_q        <= cnt_n;
				sum_q        <= sum_n;
				armed_q      <= armed_n;
				held_ready_q <= held_ready_n;
				ev_q         <= ev_n;
				rd_hit_q     <= rd_en;
				if (req.operation == OP_ARM) wanted_q <= req.expect_seq;
				if (cap) begin
					// freeze this bank as the reply and gather into the other one
					held_op_q  <= hdr_op_q;
					held_seq_q <= hdr_seq_q;
					held_len_q <= fin_len;
					bank_q     <= !bank_q;
				end
			end
			// hold the result until it is taken
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Status fields change only on an accepted request, which also refills the
	// result register, so they are shown straight from the state registers.
	assign rsp.valid        = out_valid_q;
	assign rsp.frame_event  = ev_q;
	assign rsp.reply_ready  = held_ready_q;
	assign rsp.awaiting     = armed_q;
	assign rsp.reply_opcode = held_op_q;
	assign rsp.reply_seq    = held_seq_q;
	assign rsp.reply_len    = held_len_q;
	assign rsp.read_data    = rd_hit_q ? rd_data_q : 8'h00;

endmodule

`default_nettype wire

// File: hw/rtl/dsrd_checker.sv
// Port-level checker of the deframer and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module dsrd_checker import dsrd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] frame_event,
	input logic       reply_ready,
	input logic       awaiting,
	input logic [7:0] read_data
);

	`ASSERT_NEXT(a_one_cycle_latency, in_valid && in_ready, out_valid)
	`ASSERT_IMPL(a_ready_excludes_wait, out_valid, !(reply_ready && awaiting))
	`ASSERT_IMPL(a_capture_status, out_valid && frame_event == EV_CAPTURED,
		reply_ready && !awaiting)
	`ASSERT_NEXT(a_stall_holds, out_valid && !out_ready,
		out_valid && $stable(frame_event) && $stable(read_data))

endmodule

bind dle_stx_reply_deframer dsrd_checker u_dsrd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (req.valid),
	.in_ready    (req.ready),
	.out_valid   (rsp.valid),
	.out_ready   (rsp.ready),
	.frame_event (rsp.frame_event),
	.reply_ready (rsp.reply_ready),
	.awaiting    (rsp.awaiting),
	.read_data   (rsp.read_data)
);

`default_nettype wire
